// ===== rtl/iocrb_pkg.sv =====
// Shared types and constants for the in-order commit reorder buffer.
`default_nettype none

package iocrb_pkg;

    // Number of slots held past the in-order head. Must be a power of two:
    // the slot number's low bits select the entry.
    localparam int WINDOW = 64;
    localparam int IDX_W  = $clog2(WINDOW);

    localparam int SLOT_W   = 32;
    localparam int VALUE_W  = 64;
    localparam int NODE_W   = 16;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED = 2'd0,
        ST_DUP    = 2'd1,
        ST_BEYOND = 2'd2
    } insert_status_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot_number;
        logic [VALUE_W-1:0] value_ident;
        logic               sets_master;
    } iocrb_in_t;

    typedef struct packed {
        insert_status_t     insert_status;
        logic               delivered;
        logic [SLOT_W-1:0]  delivered_slot;
        logic [VALUE_W-1:0] delivered_value;
        logic               master_changed;
        logic [NODE_W-1:0]  new_master;
        logic               own_master_ok;
        logic               last_result;
    } iocrb_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic do_insert;
        logic issue_read;
        logic load_out;
        logic out_delivered;
        logic out_last;
    } iocrb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic out_free;
    } iocrb_stat_t;

endpackage

`default_nettype wire

// ===== rtl/iocrb_ctrl.sv =====
// Controller state machine of the in-order commit reorder buffer.
`default_nettype none

module iocrb_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire iocrb_pkg::iocrb_stat_t stat,
    output iocrb_pkg::iocrb_cmd_t     cmd
);
    import iocrb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_LOOK,
        S_FETCH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.do_insert = 1'b1;
                state_next    = S_LOOK;
            end
            S_LOOK:
            begin
                if (stat.hit)
                begin
                    cmd.issue_read = 1'b1;
                    state_next     = S_FETCH;
                end
                else if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_last = 1'b1;
                    in_ready     = 1'b1;
                    if (in_valid)
                    begin
                        cmd.load_in = 1'b1;
                        state_next  = S_CHECK;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FETCH:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out      = 1'b1;
                    cmd.out_delivered = 1'b1;
                    if (stat.hit)
                    begin
                        cmd.issue_read = 1'b1;
                    end
                    else
                    begin
                        cmd.out_last = 1'b1;
                        in_ready     = 1'b1;
                        if (in_valid)
                        begin
                            cmd.load_in = 1'b1;
                            state_next  = S_CHECK;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = !in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/iocrb_datapath.sv =====
// Datapath of the in-order commit reorder buffer: slot store, head and result register.
`default_nettype none

module iocrb_datapath (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire iocrb_pkg::iocrb_in_t   in_data,
    output iocrb_pkg::iocrb_out_t       out_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [iocrb_pkg::NODE_W-1:0] cfg_data,
    input  wire iocrb_pkg::iocrb_cmd_t  cmd,
    output iocrb_pkg::iocrb_stat_t      stat
);
    import iocrb_pkg::*;

    localparam logic [SLOT_W:0] WIN_EXT = (SLOT_W + 1)'(WINDOW);

    iocrb_in_t             in_reg;
    insert_status_t        status_reg;
    insert_status_t        status_next;
    logic [WINDOW-1:0]     filled_reg;
    logic [WINDOW-1:0]     filled_next;
    logic [SLOT_W-1:0]     head_reg;
    logic [NODE_W-1:0]     master_reg;
    logic [NODE_W-1:0]     own_reg;
    logic [VALUE_W:0]      store_mem [WINDOW];
    logic [VALUE_W:0]      rd_data_reg;
    logic [SLOT_W-1:0]     rd_slot_reg;
    iocrb_out_t            out_reg;
    iocrb_out_t            out_next;
    logic                  out_valid_reg;

    logic [SLOT_W-1:0]     next_slot;
    logic [IDX_W-1:0]      next_idx;
    logic [IDX_W-1:0]      in_idx;
    logic                  below_head;
    logic                  beyond_window;
    logic                  do_store;
    logic                  changed;
    logic [NODE_W-1:0]     rd_node;

    assign next_slot = head_reg + SLOT_W'(1);
    assign next_idx  = next_slot[IDX_W-1:0];
    assign in_idx    = in_reg.slot_number[IDX_W-1:0];

    assign stat.hit      = filled_reg[next_idx];
    assign stat.out_free = !out_valid_reg || !out_stall;

    // Insert check.
    assign below_head    = in_reg.slot_number <= head_reg;
    assign beyond_window = {1'b0, in_reg.slot_number} > ({1'b0, head_reg} + WIN_EXT);

    always_comb
    begin
        do_store = 1'b0;
        if (below_head)
        begin
            status_next = ST_DUP;
        end
        else if (beyond_window)
        begin
            status_next = ST_BEYOND;
        end
        else if (filled_reg[in_idx])
        begin
            status_next = ST_DUP;
        end
        else
        begin
            status_next = ST_STORED;
            do_store    = cmd.do_insert;
        end
    end

    always_comb
    begin
        filled_next = filled_reg;
        if (do_store)
        begin
            filled_next[in_idx] = 1'b1;
        end
        if (cmd.issue_read)
        begin
            filled_next[next_idx] = 1'b0;
        end
    end

    // Result formation.
    assign rd_node = rd_data_reg[NODE_W:1];
    assign changed = cmd.out_delivered && rd_data_reg[0];

    always_comb
    begin
        out_next.insert_status   = status_reg;
        out_next.delivered       = cmd.out_delivered;
        out_next.delivered_slot  = cmd.out_delivered ? rd_slot_reg : '0;
        out_next.delivered_value = cmd.out_delivered ? rd_data_reg[VALUE_W:1] : '0;
        out_next.master_changed  = changed;
        out_next.new_master      = changed ? rd_node : master_reg;
        out_next.own_master_ok   = changed && (rd_node == own_reg);
        out_next.last_result     = cmd.out_last;
    end

    // Slot store: value id with the set-master flag in bit zero.
    always_ff @(posedge clk)
    begin
        if (do_store)
        begin
            store_mem[in_idx] <= {in_reg.value_ident, in_reg.sets_master};
        end
        if (cmd.issue_read)
        begin
            rd_data_reg <= store_mem[next_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg <= in_data;
        end
        if (cmd.do_insert)
        begin
            status_reg <= status_next;
        end
        if (cmd.issue_read)
        begin
            rd_slot_reg <= next_slot;
        end
        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg    <= '0;
            head_reg      <= '0;
            master_reg    <= '0;
            own_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            filled_reg <= filled_next;
            if (cmd.issue_read)
            begin
                head_reg <= next_slot;
            end
            if (cmd.load_out)
            begin
                master_reg <= out_next.new_master;
            end
            if (cfg_valid)
            begin
                own_reg <= cfg_data;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A read is only issued for an entry that is actually filled.
    a_read_hits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue_read |-> filled_reg[next_idx])
        else $error("read issued for an empty entry");

    // The result register is never overwritten while it still holds a stalled result.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten while stalled");

    // Each read retires exactly one slot.
    a_head_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue_read |=> (head_reg == SLOT_W'($past(head_reg) + SLOT_W'(1))))
        else $error("head did not advance by one");

    // Insert and drain never overlap.
    a_insert_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.do_insert && (cmd.issue_read || cmd.load_out)))
        else $error("insert overlaps drain");

endmodule

`default_nettype wire

// ===== rtl/in_order_commit_reorder_buffer_top.sv =====
// Top level of the in-order commit reorder buffer.
//
// Decided log entries (slot number, value id, set-master flag) arrive on the
// input channel in any order. A transaction moves when in_valid is high and
// in_stall is low. Each accepted entry is checked against a window of WINDOW
// slots just past the in-order head and stored unless it is a repeat or
// lies beyond the window. The store is then drained in slot order: every
// entry from the head onward with no hole before it leaves as one result
// transaction, the last result of an input marked by last_result. When
// nothing drains, one result reports only the insert status.
// Sequence: an input that delivers nothing passes the check state and loads
// its result in the look state; one that delivers entries issues its first
// read in the look state, loads each result in the fetch state, one per cycle
// unless out_stall holds them, paced by the single read port of the slot
// store. The next input is taken in the cycle the final result is loaded.
// The result sits in an output register; while out_stall is high it holds
// and the drain pauses, but a finished result does not block acceptance.
// The own node id is written over the cfg channel, always ready.
// Reset clears the head, the master, the node id and all fill flags at once.
`default_nettype none

module in_order_commit_reorder_buffer_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire iocrb_pkg::iocrb_in_t         in_data,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output iocrb_pkg::iocrb_out_t             out_data,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [iocrb_pkg::NODE_W-1:0] cfg_data
);
    import iocrb_pkg::*;

    iocrb_cmd_t  cmd;
    iocrb_stat_t stat;

    // Sequencing of insert, drain and result loading.
    iocrb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Slot store, head, master and result register.
    iocrb_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire
